### rtl/oors_pkg.sv
// Package: shared types, codes and defaults for the oldest-or-richest server.
package oors_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int AMOUNT_W     = 31;
    localparam int TICKET_W     = 32;

    // Request codes
    localparam logic [1:0] OP_ARRIVAL = 2'd0;
    localparam logic [1:0] OP_OLDEST  = 2'd1;
    localparam logic [1:0] OP_LARGEST = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_SERVED = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // Selection modes of the shared compare unit
    localparam logic [1:0] SEL_FREE    = 2'd0;
    localparam logic [1:0] SEL_OLDEST  = 2'd1;
    localparam logic [1:0] SEL_LARGEST = 2'd2;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [AMOUNT_W-1:0] amount;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [TICKET_W-1:0] ticket;
    } t_out_item;

    typedef struct packed {
        logic                valid;
        logic [AMOUNT_W-1:0] amount;
        logic [TICKET_W-1:0] ticket;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic       start;
        logic       vld;
        logic [1:0] mode;
    } t_sel_ctl;

endpackage

### rtl/oors_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module oors_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/oors_sel.sv
// Shared compare unit: keeps the best entry seen so far during a pool scan.
module oors_sel import oors_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_sel_ctl                    i_ctl,
    input  t_entry                      i_entry,
    input  logic [$clog2(CAPACITY)-1:0] i_idx,
    output logic                        o_found,
    output logic [$clog2(CAPACITY)-1:0] o_idx,
    output logic [AMOUNT_W-1:0]         o_amount,
    output logic [TICKET_W-1:0]         o_ticket
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic                r_found;
    logic [IDX_W-1:0]    r_idx;
    logic [AMOUNT_W-1:0] r_amount;
    logic [TICKET_W-1:0] r_ticket;
    logic                better;

    always_comb begin
        better = 1'b0;
        unique case (i_ctl.mode)
            SEL_FREE: begin
                // first free slot wins
                better = !i_entry.valid && !r_found;
            end
            SEL_OLDEST: begin
                better = i_entry.valid && (!r_found || (i_entry.ticket < r_ticket));
            end
            SEL_LARGEST: begin
                better = i_entry.valid && (!r_found || (i_entry.amount > r_amount) ||
                         ((i_entry.amount == r_amount) && (i_entry.ticket < r_ticket)));
            end
            default: begin
                better = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.start) begin
            r_found <= 1'b0;
        end else if (i_ctl.vld && better) begin
            r_found  <= 1'b1;
            r_idx    <= i_idx;
            r_amount <= i_entry.amount;
            r_ticket <= i_entry.ticket;
        end
    end

    assign o_found  = r_found;
    assign o_idx    = r_idx;
    assign o_amount = r_amount;
    assign o_ticket = r_ticket;

endmodule

### rtl/oldest_or_richest_server_top.sv
// Top level of the oldest-or-richest server: sequencer, pool memory and output register.
//
// A pool of CAPACITY entries, each an amount under a ticket counting up from 1. An arrival
// stores its amount in the lowest free slot and returns the new ticket; a serve-oldest returns
// and removes the smallest ticket; a serve-largest returns and removes the greatest amount,
// ties to the smaller ticket. Opcode 3 serves largest. Every transaction gives one result.
// After reset every entry of the pool memory is cleared, with the input stalled. A serve
// on an empty pool, or an arrival on a full pool or after ticket 0xFFFFFFFF, presents its
// result the cycle after acceptance; any other transaction presents its result after the
// scan that reads one pool entry per cycle from the single-read-port memory into one shared
// compare unit, then a write to the chosen slot. One transaction is worked on at a time; the
// next is taken the cycle after its result has left the output.
module oldest_or_richest_server_top import oors_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CAPACITY - 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    logic [1:0]          r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic [1:0]          r_mode;
    logic [AMOUNT_W-1:0] r_amount;
    logic [TICKET_W-1:0] r_next_ticket;
    logic [CNT_W-1:0]    r_held;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                in_acc;
    logic [1:0]          n_mode;
    logic                rd_en;
    logic                we;
    logic [IDX_W-1:0]    waddr;
    t_entry              wdata;
    t_entry              rdata;
    t_sel_ctl            sel_ctl;
    logic                best_found;
    logic [IDX_W-1:0]    best_idx;
    logic [AMOUNT_W-1:0] best_amount;
    logic [TICKET_W-1:0] best_ticket;

    assign o_in_stall = (r_state != S_IDLE) || r_out_valid;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        if (i_in_data.opcode == OP_ARRIVAL) begin
            n_mode = SEL_FREE;
        end else if (i_in_data.opcode[1]) begin
            n_mode = SEL_LARGEST;
        end else begin
            n_mode = SEL_OLDEST;
        end
    end

    assign rd_en = (r_state == S_SCAN) && (r_cnt < CAP_CNT);
    assign we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign waddr = (r_state == S_CLEAR) ? r_cnt[IDX_W-1:0] : best_idx;

    always_comb begin
        if (r_state == S_CLEAR) begin
            wdata = '0;
        end else if (r_mode == SEL_FREE) begin
            wdata = '{valid: 1'b1, amount: r_amount, ticket: r_next_ticket};
        end else begin
            // drop the entry: clear its valid flag
            wdata = '{valid: 1'b0, amount: best_amount, ticket: best_ticket};
        end
    end

    assign sel_ctl = '{start: in_acc, vld: r_cmp_vld, mode: r_mode};

    oors_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_pool (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    oors_sel #(
        .CAPACITY (CAPACITY)
    ) u_sel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (sel_ctl),
        .i_entry  (rdata),
        .i_idx    (r_cmp_idx),
        .o_found  (best_found),
        .o_idx    (best_idx),
        .o_amount (best_amount),
        .o_ticket (best_ticket)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_cnt         <= '0;
            r_cmp_vld     <= 1'b0;
            r_next_ticket <= TICKET_W'(1);
            r_held        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_cmp_vld <= rd_en;
            r_cmp_idx <= r_cnt[IDX_W-1:0];
            unique case (r_state)
                S_CLEAR: begin
                    if (r_cnt == LAST_CNT) begin
                        r_state <= S_IDLE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_mode   <= n_mode;
                        r_amount <= i_in_data.amount;
                        r_cnt    <= '0;
                        if ((n_mode == SEL_FREE) &&
                            ((r_held == CAP_CNT) || (r_next_ticket == '0))) begin
                            r_out_valid <= 1'b1;
                            r_out       <= '{status: ST_FULL, ticket: '0};
                        end else if ((n_mode != SEL_FREE) && (r_held == '0)) begin
                            r_out_valid <= 1'b1;
                            r_out       <= '{status: ST_EMPTY, ticket: '0};
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (rd_en) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_cmp_vld && (r_cmp_idx == LAST_IDX)) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                    if (r_mode == SEL_FREE) begin
                        r_out         <= '{status: ST_STORED, ticket: r_next_ticket};
                        r_next_ticket <= r_next_ticket + 1'b1;
                        r_held        <= r_held + 1'b1;
                    end else begin
                        r_out  <= '{status: ST_SERVED, ticket: best_ticket};
                        r_held <= r_held - 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CAP_CNT)
        else $error("held count exceeds pool capacity");

    a_scan_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> best_found)
        else $error("scan ended without a selected slot");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> ((r_state == S_SCAN) || o_out_valid))
        else $error("accepted transaction neither scanned nor answered");

    a_stored_ticket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_STORED)) |-> (o_out_data.ticket != '0))
        else $error("stored transaction reported ticket zero");

endmodule

### dv/tb.sv
// Self-checking testbench for the oldest-or-richest server: pool tracker, drivers and watchdog.
`timescale 1ns / 100ps

module tb;
    import oors_pkg::*;

    localparam int          POOL_DEPTH  = CAPACITY_DEF;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          PHASE_ITEMS = 350;
    localparam logic [1:0]  OP_SPARE    = 2'd3;  // decodes as serve largest

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    // Tracks pool contents and the replies still owed by the block
    class pool_tracker;
        bit                pool_used [POOL_DEPTH];
        bit [AMOUNT_W-1:0] pool_amount [POOL_DEPTH];
        bit [TICKET_W-1:0] pool_ticket [POOL_DEPTH];
        bit [TICKET_W-1:0] next_ticket;
        int                held;
        t_out_item         awaited [$];
        int                mismatches;

        function new();
            foreach (pool_used[i]) pool_used[i] = 1'b0;
            next_ticket = 1;
            held        = 0;
            mismatches  = 0;
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            mismatches++;
        endtask

        function t_out_item predict_reply(t_in_item req);
            t_out_item r;
            int        i;
            int        best;
            bit        better;
            bit        by_amount;
            r.status = ST_FULL;
            r.ticket = '0;
            if (req.opcode == OP_ARRIVAL) begin
                if (held < POOL_DEPTH && next_ticket != 0) begin
                    for (i = 0; i < POOL_DEPTH; i++) begin
                        if (!pool_used[i]) begin
                            pool_used[i]   = 1'b1;
                            pool_amount[i] = req.amount;
                            pool_ticket[i] = next_ticket;
                            held++;
                            r.status    = ST_STORED;
                            r.ticket    = next_ticket;
                            next_ticket = next_ticket + 1;
                            break;
                        end
                    end
                end
            end else begin
                by_amount = (req.opcode != OP_OLDEST);
                best      = -1;
                for (i = 0; i < POOL_DEPTH; i++) begin
                    if (pool_used[i]) begin
                        if (best < 0)
                            better = 1'b1;
                        else if (by_amount)
                            better = pool_amount[i] > pool_amount[best] ||
                                     (pool_amount[i] == pool_amount[best] &&
                                      pool_ticket[i] < pool_ticket[best]);
                        else
                            better = pool_ticket[i] < pool_ticket[best];
                        if (better)
                            best = i;
                    end
                end
                if (best < 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pool_used[best] = 1'b0;
                    held--;
                    r.status = ST_SERVED;
                    r.ticket = pool_ticket[best];
                end
            end
            return r;
        endfunction

        task note_request(t_in_item req);
            awaited.insert(awaited.size(), predict_reply(req));
        endtask

        task check_response(t_out_item got);
            t_out_item want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected reply status %0d ticket %0d",
                                 got.status, got.ticket));
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, wanted %0d (ticket wanted %0d)",
                                 got.status, want.status, want.ticket));
            if (got.ticket !== want.ticket)
                report($sformatf("ticket %0d, wanted %0d", got.ticket, want.ticket));
        endtask
    endclass

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_item  in_data    = '0;
    logic      out_stall  = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    int          idle_pct  = 0;
    int          stall_pct = 0;
    pool_tracker tracker   = new();

    oldest_or_richest_server_top #(
        .CAPACITY (POOL_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !out_stall)
            tracker.check_response(o_out_data);
    end

    // End the run if no transaction moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Called and returns at a falling edge; holds the transaction until taken
    task automatic push_request(t_in_item req);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        tracker.note_request(req);
        @(negedge i_clk);
    endtask

    task automatic push_op(logic [1:0] op, logic [AMOUNT_W-1:0] amt);
        t_in_item req;
        req.opcode = op;
        req.amount = amt;
        push_request(req);
    endtask

    function automatic t_in_item make_request(t_mix mix);
        t_in_item req;
        int       arrive_pct;
        int       pick;
        case (mix)
            MIX_FILL:  arrive_pct = 85;
            MIX_DRAIN: arrive_pct = 15;
            default:   arrive_pct = 50;
        endcase
        // Narrow amounts force ties on serve largest
        case ($urandom_range(9))
            0, 1, 2: req.amount = AMOUNT_W'($urandom_range(7));
            3:       req.amount = $urandom_range(1) ? '1 : '0;
            default: req.amount = AMOUNT_W'($urandom);
        endcase
        if ($urandom_range(99) < arrive_pct) begin
            req.opcode = OP_ARRIVAL;
        end else begin
            pick = $urandom_range(9);
            if (pick < 5)
                req.opcode = OP_OLDEST;
            else if (pick < 9)
                req.opcode = OP_LARGEST;
            else
                req.opcode = OP_SPARE;
        end
        return req;
    endfunction

    initial begin : stimulus
        int   phase;
        int   left;
        int   run;
        t_mix mix;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty pool on every serve code, then extremes and ties
        push_op(OP_OLDEST,  '0);
        push_op(OP_LARGEST, '1);
        push_op(OP_SPARE,   '0);
        push_op(OP_ARRIVAL, '0);
        push_op(OP_ARRIVAL, '1);
        push_op(OP_ARRIVAL, '1);
        push_op(OP_ARRIVAL, 31'h5555_5555);
        push_op(OP_ARRIVAL, 31'h2AAA_AAAA);
        push_op(OP_ARRIVAL, 31'd1);
        push_op(OP_LARGEST, '0);
        push_op(OP_SPARE,   '1);
        push_op(OP_OLDEST,  '1);
        push_op(OP_LARGEST, '0);
        push_op(OP_OLDEST,  '0);
        push_op(OP_OLDEST,  '0);
        push_op(OP_OLDEST,  '0);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin idle_pct = 22; stall_pct = 57; end
                1:       begin idle_pct = 57; stall_pct = 22; end
                default: begin idle_pct = 0;  stall_pct = 0;  end
            endcase
            left = PHASE_ITEMS;
            while (left > 0) begin
                run = $urandom_range(120, 20);
                mix = t_mix'($urandom_range(2));
                while (run > 0 && left > 0) begin
                    push_request(make_request(mix));
                    run--;
                    left--;
                end
            end
        end
        in_valid <= 1'b0;

        while (tracker.awaited.size() != 0)
            @(posedge i_clk);
        repeat (2 * POOL_DEPTH) @(posedge i_clk);
        if (tracker.awaited.size() != 0)
            tracker.report($sformatf("%0d replies never arrived", tracker.awaited.size()));

        if (tracker.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
